>>> src/lpab_pkg.sv
// Shared types and constants for the lidar point angle binner.
`default_nettype none
package lpab_pkg;
    localparam int FULL_TURN = 5898240;
    localparam int CORDIC_STEPS = 16;
    localparam int CWIDTH = 48;
    localparam int AWIDTH = 32;

    localparam logic [0:0] CFG_WARMUP = 1'b0;
    localparam logic [0:0] CFG_MOUNT  = 1'b1;

    typedef struct packed {
        logic load;
        logic cordic_step;
        logic div_step;
        logic wrap_step;
        logic bin_mul;
        logic bin_div_step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic bin_done;
        logic wrap_done;
    } t_status;

    function automatic logic [19:0] atan_entry(input logic [3:0] i);
        logic [19:0] v;
        unique case (i)
            4'd0: v = 20'd737280;  4'd1: v = 20'd435242;
            4'd2: v = 20'd229970;  4'd3: v = 20'd116736;
            4'd4: v = 20'd58595;   4'd5: v = 20'd29326;
            4'd6: v = 20'd14667;   4'd7: v = 20'd7334;
            4'd8: v = 20'd3667;    4'd9: v = 20'd1833;
            4'd10: v = 20'd917;    4'd11: v = 20'd458;
            4'd12: v = 20'd229;    4'd13: v = 20'd115;
            4'd14: v = 20'd57;     default: v = 20'd29;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

>>> src/lpab_datapath.sv
// Datapath: CORDIC, interpolation divider, wrap loop and reciprocal bin scaling.
`default_nettype none
module lpab_datapath #(
    parameter int SCAN_BINS = 800
) (
    input  wire logic                i_clk,
    input  wire lpab_pkg::t_cmd      i_cmd,
    input  wire logic [15:0]         i_raw_distance,
    input  wire logic [15:0]         i_start_angle_raw,
    input  wire logic [15:0]         i_end_angle_raw,
    input  wire logic [6:0]          i_point_count,
    input  wire logic [5:0]          i_point_index,
    input  wire logic [14:0]         i_mount_base_angle,
    output lpab_pkg::t_status        o_status,
    output logic [9:0]               o_bin_index,
    output logic [13:0]              o_distance_mm
);
    // bin numerator width, wide enough for SCAN_BINS up to 4096
    localparam int BW = 36;
    // a full turn is 45 * 2^17: quotient = ((n >> 17) * ceil(2^22 / 45)) >> 22
    localparam logic [16:0] BQ_RECIP = 17'd93207;

    logic signed [lpab_pkg::CWIDTH-1:0] r_x, r_y;
    logic signed [lpab_pkg::AWIDTH-1:0] r_z, r_ang;
    logic [3:0]  r_i;
    logic [13:0] r_d;
    // interpolation divider: unsigned magnitude, sign held
    logic [29:0] r_num;
    logic [6:0]  r_den;
    logic [30:0] r_rem;
    logic [4:0]  r_dcnt;
    logic        r_neg, r_div_on;
    logic signed [lpab_pkg::AWIDTH-1:0] r_a;
    logic [BW-1:0] r_bn;
    logic [9:0]    r_bq;
    logic          r_bdone;

    logic signed [lpab_pkg::CWIDTH-1:0] xs, ys;
    logic signed [16:0] diff;
    logic [15:0] mag;
    logic [21:0] prod;
    logic [30:0] rem_sh;
    logic        q_bit;
    logic [29:0] q_full;
    logic signed [lpab_pkg::AWIDTH-1:0] quo;
    logic [BW-1:0] bprod;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        diff = 17'(signed'({1'b0, i_end_angle_raw[15:1]})) -
               17'(signed'({1'b0, i_start_angle_raw[15:1]}));
        mag = (diff < 0) ? 16'(-diff) : 16'(diff);
        prod = 22'(mag) * 22'(i_point_index);
        rem_sh = {r_rem[29:0], r_num[29]};
        q_bit = (rem_sh >= 31'(r_den));
        // quotient including the bit decided this beat
        q_full = {r_num[28:0], q_bit};
        quo = r_neg ? -lpab_pkg::AWIDTH'(q_full) : lpab_pkg::AWIDTH'(q_full);
        bprod = BW'(r_bn[BW-1:17]) * BW'(BQ_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d   <= i_raw_distance[15:2];
            r_x   <= lpab_pkg::CWIDTH'(64'd901500 * 64'(i_raw_distance[15:2]));
            r_y   <= lpab_pkg::CWIDTH'(64'sd1916 *
                     (64'sd100 * 64'(i_raw_distance[15:2]) - 64'sd9015));
            r_z   <= '0;
            r_i   <= '0;
            r_ang <= lpab_pkg::AWIDTH'({i_start_angle_raw[15:1], 8'd0});
            r_neg <= diff < 0;
            r_num <= {prod, 8'd0};
            r_den <= i_point_count - 7'd1;
            r_div_on <= i_point_count > 7'd1;
            r_rem <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.cordic_step) begin
            r_i <= r_i + 4'd1;
            if (r_y >= 0) begin
                r_x <= r_x + ys; r_y <= r_y - xs;
                r_z <= r_z + lpab_pkg::AWIDTH'(lpab_pkg::atan_entry(r_i));
            end else begin
                r_x <= r_x - ys; r_y <= r_y + xs;
                r_z <= r_z - lpab_pkg::AWIDTH'(lpab_pkg::atan_entry(r_i));
            end
        end
        if (i_cmd.div_step) begin
            // restoring division, one quotient bit per beat
            r_dcnt <= r_dcnt + 5'd1;
            r_num <= q_full;
            if (q_bit) r_rem <= rem_sh - 31'(r_den);
            else       r_rem <= rem_sh;
            if (r_dcnt == 5'd29) begin
                r_a <= lpab_pkg::AWIDTH'({i_mount_base_angle, 8'd0}) - r_ang -
                       (r_div_on ? quo : '0) + (r_d == 0 ? '0 : r_z);
            end
        end
        if (i_cmd.wrap_step) begin
            if (r_a < 0) r_a <= r_a + lpab_pkg::FULL_TURN;
            else if (r_a >= lpab_pkg::FULL_TURN) r_a <= r_a - lpab_pkg::FULL_TURN;
        end
        if (i_cmd.bin_mul) begin
            r_bn <= BW'(r_a[22:0]) * BW'(SCAN_BINS - 1) + BW'(lpab_pkg::FULL_TURN / 2);
            r_bdone <= 1'b0;
        end
        if (i_cmd.bin_div_step) begin
            r_bq <= bprod[31:22];
            r_bdone <= 1'b1;
        end
    end

    assign o_status = '{div_done:  (r_dcnt == 5'd30),
                        bin_done:  r_bdone,
                        wrap_done: (r_a >= 0) && (r_a < lpab_pkg::FULL_TURN)};
    assign o_bin_index   = r_bq;
    assign o_distance_mm = r_d;
endmodule
`default_nettype wire

>>> src/lpab_ctrl.sv
// Controller: warm-up tracking, sequencing and output handshake.
`default_nettype none
module lpab_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire logic           i_stall,
    input  wire logic           i_first_in_packet,
    input  wire logic           i_revolution_start,
    input  wire logic [7:0]     i_warmup_revolutions,
    input  wire lpab_pkg::t_status i_status,
    output lpab_pkg::t_cmd      o_cmd,
    output logic                o_publish_scan,
    output logic                o_dropped
);
    typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_DIV, S_WRAP, S_BMUL, S_BDIV, S_OUT}
        t_state;
    t_state r_state;
    logic [7:0] r_warm;
    logic r_pdrop, r_pub, r_drop;
    logic [3:0] r_cnt;
    logic acc, drop_now;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_publish_scan = r_pub;
    assign o_dropped = r_drop;
    assign drop_now = i_first_in_packet ? (i_revolution_start && r_warm < i_warmup_revolutions)
                                        : r_pdrop;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = acc;
        o_cmd.cordic_step = (r_state == S_CORDIC);
        o_cmd.div_step = (r_state == S_DIV) && !i_status.div_done;
        o_cmd.wrap_step = (r_state == S_WRAP);
        o_cmd.bin_mul = (r_state == S_BMUL);
        o_cmd.bin_div_step = (r_state == S_BDIV) && !i_status.bin_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_warm <= '0; r_pdrop <= 1'b0;
            r_pub <= 1'b0; r_drop <= 1'b0; r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (acc) begin
                    if (i_first_in_packet) r_pdrop <= drop_now;
                    if (i_first_in_packet && drop_now) r_warm <= r_warm + 8'd1;
                    r_drop <= drop_now;
                    r_pub <= i_first_in_packet && i_revolution_start && !drop_now;
                    r_cnt <= '0;
                    r_state <= drop_now ? S_OUT : S_CORDIC;
                end
                S_CORDIC: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) r_state <= S_DIV;
                end
                S_DIV:  if (i_status.div_done) r_state <= S_WRAP;
                S_WRAP: if (i_status.wrap_done) r_state <= S_BMUL;
                S_BMUL: r_state <= S_BDIV;
                S_BDIV: if (i_status.bin_done) r_state <= S_OUT;
                S_OUT:  if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_warm_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $changed(r_warm) |-> $past(r_warm) < $past(i_warmup_revolutions))
        else $error("warm-up count advanced past limit");
    a_pub_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(r_pub && r_drop)) else $error("publish on dropped beat");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result lost under stall");
endmodule
`default_nettype wire

>>> src/lidar_point_angle_binner_core.sv
// Top level of the lidar point angle binner.
//  channel | dir | handshake                 | beat
//  in      | in  | i_valid / o_stall         | one point with packet header
//  out     | out | o_valid / i_stall         | bin, distance, publish, drop
//  cfg     | in  | i_cfg_we / i_cfg_index    | one register write
// A kept point runs the CORDIC, the interpolation divider, the wrap loop (which adds or
// removes one full turn per step until the angle lies within a full turn), one multiply
// and the bin scaling, in that order; the wrap loop sets the spread in processing time.
// Dropped points are valid the cycle after acceptance. Reset is synchronous, active
// low; it loads the register defaults and clears the warm-up count. A stalled result
// holds, and the input stalls until the result leaves.
`default_nettype none
module lidar_point_angle_binner_core #(
    parameter int SCAN_BINS = 800
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_raw_distance,
    input  wire logic [15:0] i_start_angle_raw,
    input  wire logic [15:0] i_end_angle_raw,
    input  wire logic [6:0]  i_point_count,
    input  wire logic [5:0]  i_point_index,
    input  wire logic        i_first_in_packet,
    input  wire logic        i_revolution_start,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [9:0]       o_bin_index,
    output logic [13:0]      o_distance_mm,
    output logic             o_publish_scan,
    output logic             o_dropped,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);
    logic [7:0]  r_warmup_revolutions;
    logic [14:0] r_mount_base_angle;
    lpab_pkg::t_cmd cmd;
    lpab_pkg::t_status status;
    logic [9:0]  bin;
    logic [13:0] dp_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_revolutions <= 8'd10;
            r_mount_base_angle <= 15'd10752;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpab_pkg::CFG_WARMUP: r_warmup_revolutions <= i_cfg_data[7:0];
                lpab_pkg::CFG_MOUNT:  r_mount_base_angle <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lpab_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_first_in_packet, .i_revolution_start,
        .i_warmup_revolutions(r_warmup_revolutions),
        .i_status(status), .o_cmd(cmd),
        .o_publish_scan, .o_dropped
    );

    lpab_datapath #(.SCAN_BINS(SCAN_BINS)) u_dp (
        .i_clk, .i_cmd(cmd), .i_raw_distance, .i_start_angle_raw, .i_end_angle_raw,
        .i_point_count, .i_point_index, .i_mount_base_angle(r_mount_base_angle),
        .o_status(status), .o_bin_index(bin), .o_distance_mm(dp_distance)
    );

    // zero the payload of a dropped point
    assign o_bin_index   = o_dropped ? 10'd0 : bin;
    assign o_distance_mm = o_dropped ? 14'd0 : dp_distance;
endmodule
`default_nettype wire
